// ===== sv/ctc_pkg.sv =====
package ctc_pkg;

    localparam int WORD_CHARS_KEPT = 8;
    localparam int NUM_KEYWORDS    = 10;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NUMBER     = 3'd0,
        KIND_KEYWORD    = 3'd1,
        KIND_IDENTIFIER = 3'd2,
        KIND_SYMBOL     = 3'd3,
        KIND_LINES      = 3'd4
    } kind_t;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_ZERO       = 8'h30;

    // keyword text packed with the first character in the low byte
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'h0000_0000_0072_6f66,  // for
        64'h0000_0065_6c69_6877,  // while
        64'h0000_0000_0000_6f64,  // do
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0074_616f_6c66,  // float
        64'h0000_0000_7261_6863,  // char
        64'h0000_656c_6275_6f64,  // double
        64'h0000_6369_7461_7473,  // static
        64'h0000_6863_7469_7773,  // switch
        64'h0000_0000_6573_6163   // case
    };

    localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{
        8'd3, 8'd5, 8'd2, 8'd3, 8'd5, 8'd4, 8'd6, 8'd6, 8'd6, 8'd4
    };

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] number_value;
        logic [3:0]  keyword_number;
        logic [63:0] word_text;
        logic [7:0]  word_length;
        logic [7:0]  symbol_code;
        logic [31:0] line_total;
        logic        last_of_run;
    } result_t;

endpackage

// ===== sv/ctc_char_if.sv =====
interface ctc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== sv/ctc_token_if.sv =====
interface ctc_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] number_value;
    logic [3:0]  keyword_number;
    logic [63:0] word_text;
    logic [7:0]  word_length;
    logic [7:0]  symbol_code;
    logic [31:0] line_total;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output number_value, output keyword_number,
        output word_text, output word_length, output symbol_code, output line_total,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input number_value, input keyword_number,
        input word_text, input word_length, input symbol_code, input line_total,
        input last_of_run, output ready
    );
endinterface

// ===== sv/c_token_classifier_unit.sv =====
// c_token_classifier_unit: splits a stream of ascii characters into tokens
//
// chars  : one request per character (char_code), or an end-of-text request
//          (end_of_text high) that flushes a pending token and reports the
//          line total; an item is taken when valid and ready are both high
// tokens : result requests (number, keyword, identifier, symbol, line total);
//          last_of_run marks the final result caused by one character
//
// each character is classified against the scanner state in the cycle it is
// taken and its results sit in a two-entry result register the next cycle.
// a character that gives two results holds chars.ready low until the first
// of them leaves. the two-entry result register sets the rate: a new
// character is taken whenever it is empty or its only entry leaves in the
// same cycle.
//
// reset clears the scanner (idle, line count one) and the result register.
// when tokens.ready is low the results wait and chars.ready drops once the
// result register cannot take the next character's results.
module c_token_classifier_unit #(
    parameter int WORD_CHARS_KEPT = ctc_pkg::WORD_CHARS_KEPT
) (
    input  logic        clk,
    input  logic        rst_n,
    ctc_char_if.sink    chars,
    ctc_token_if.source tokens
);

    ctc_pkg::mode_t   mode_reg, mode_next;
    logic [31:0]      acc_reg, acc_next;
    logic [63:0]      buf_reg, buf_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [31:0]      line_reg, line_next;

    ctc_pkg::result_t slot0_reg, slot0_next;
    ctc_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]       fill_reg, fill_next;

    logic push;
    logic pop;

    logic [7:0] c;
    logic       eot;
    logic       is_digit;
    logic       is_letter;
    logic       is_word_char;
    logic       continues;
    logic [35:0] acc_times_ten;
    logic [63:0] buf_added;
    logic [7:0]  cnt_added;

    logic             kw_found;
    logic [3:0]       kw_index;
    ctc_pkg::result_t flush_res;
    ctc_pkg::result_t second_res;
    logic             flush_en;
    logic             second_en;
    ctc_pkg::result_t r0, r1;
    logic [1:0]       res_count;

    assign c   = chars.char_code;
    assign eot = chars.end_of_text;

    assign is_digit     = c inside {[8'h30:8'h39]};
    assign is_letter    = c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    assign is_word_char = is_letter || is_digit || c == ctc_pkg::CH_UNDERSCORE
                          || c == ctc_pkg::CH_DOLLAR;

    assign continues = !eot && ((mode_reg == ctc_pkg::MODE_NUM && is_digit)
                       || (mode_reg == ctc_pkg::MODE_WORD && is_word_char));

    // times ten plus the new digit, as two shifts and two adds
    assign acc_times_ten = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                           + {32'd0, c[3:0] - ctc_pkg::CH_ZERO[3:0]};

    always_comb
    begin
        buf_added = buf_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (i < WORD_CHARS_KEPT && cnt_reg == 8'(i))
            begin
                buf_added[8*i +: 8] = c;
            end
        end
        cnt_added = (cnt_reg == 8'hff) ? cnt_reg : cnt_reg + 8'd1;
    end

    // keyword lookup over the pending word
    always_comb
    begin
        kw_found = 1'b0;
        kw_index = '0;
        for (int i = ctc_pkg::NUM_KEYWORDS - 1; i >= 0; i--)
        begin
            if (cnt_reg == ctc_pkg::KW_LEN[i] && buf_reg == ctc_pkg::KW_TEXT[i])
            begin
                kw_found = 1'b1;
                kw_index = 4'(i);
            end
        end
    end

    // next state of the scanner
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        if (push)
        begin
            if (eot)
            begin
                mode_next = ctc_pkg::MODE_IDLE;
                acc_next  = '0;
                buf_next  = '0;
                cnt_next  = '0;
                line_next = 32'd1;
            end
            else if (continues && mode_reg == ctc_pkg::MODE_NUM)
            begin
                acc_next = (acc_times_ten[35:32] != 4'b0000) ? 32'hffff_ffff
                                                             : acc_times_ten[31:0];
            end
            else if (continues)
            begin
                buf_next = buf_added;
                cnt_next = cnt_added;
            end
            else
            begin
                mode_next = ctc_pkg::MODE_IDLE;
                acc_next  = '0;
                buf_next  = '0;
                cnt_next  = '0;
                if (is_digit)
                begin
                    mode_next = ctc_pkg::MODE_NUM;
                    acc_next  = {28'd0, c[3:0] - ctc_pkg::CH_ZERO[3:0]};
                end
                else if (is_letter)
                begin
                    mode_next = ctc_pkg::MODE_WORD;
                    buf_next  = {56'd0, c};
                    cnt_next  = 8'd1;
                end
                else if (c == ctc_pkg::CH_NEWLINE && line_reg != 32'hffff_ffff)
                begin
                    line_next = line_reg + 32'd1;
                end
            end
        end
    end

    // results of the current character
    always_comb
    begin
        flush_res             = '0;
        flush_res.line_total  = line_reg;
        flush_en              = !continues && mode_reg != ctc_pkg::MODE_IDLE;
        if (mode_reg == ctc_pkg::MODE_NUM)
        begin
            flush_res.token_kind   = ctc_pkg::KIND_NUMBER;
            flush_res.number_value = acc_reg;
        end
        else
        begin
            flush_res.token_kind  = kw_found ? ctc_pkg::KIND_KEYWORD
                                             : ctc_pkg::KIND_IDENTIFIER;
            flush_res.keyword_number = kw_found ? kw_index : 4'd0;
            flush_res.word_text   = buf_reg;
            flush_res.word_length = cnt_reg;
        end

        second_res            = '0;
        second_res.line_total = line_reg;
        second_res.last_of_run = 1'b1;
        if (eot)
        begin
            second_en             = 1'b1;
            second_res.token_kind = ctc_pkg::KIND_LINES;
        end
        else
        begin
            second_en = !continues && !is_digit && !is_letter && c != ctc_pkg::CH_SPACE
                        && c != ctc_pkg::CH_TAB && c != ctc_pkg::CH_NEWLINE;
            second_res.token_kind  = ctc_pkg::KIND_SYMBOL;
            second_res.symbol_code = c;
        end

        r1 = second_res;
        if (flush_en)
        begin
            r0             = flush_res;
            r0.last_of_run = !second_en;
            res_count      = second_en ? 2'd2 : 2'd1;
        end
        else
        begin
            r0        = second_res;
            res_count = second_en ? 2'd1 : 2'd0;
        end
    end

    assign pop        = tokens.valid && tokens.ready;
    assign chars.ready = (fill_reg == 2'd0) || (fill_reg == 2'd1 && tokens.ready);
    assign push       = chars.valid && chars.ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill_next  = fill_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            fill_next  = fill_reg - 2'd1;
        end
        if (push)
        begin
            slot0_next = r0;
            slot1_next = r1;
            fill_next  = res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ctc_pkg::MODE_IDLE;
            acc_reg  <= '0;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            line_reg <= 32'd1;
            fill_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign tokens.valid          = fill_reg != 2'd0;
    assign tokens.token_kind     = slot0_reg.token_kind;
    assign tokens.number_value   = slot0_reg.number_value;
    assign tokens.keyword_number = slot0_reg.keyword_number;
    assign tokens.word_text      = slot0_reg.word_text;
    assign tokens.word_length    = slot0_reg.word_length;
    assign tokens.symbol_code    = slot0_reg.symbol_code;
    assign tokens.line_total     = slot0_reg.line_total;
    assign tokens.last_of_run    = slot0_reg.last_of_run;

    // end of text leaves the scanner as after reset
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push && eot |=> mode_reg == ctc_pkg::MODE_IDLE && line_reg == 32'd1
                        && cnt_reg == 8'd0 && acc_reg == 32'd0)
        else $error("scanner not cleared after end of text");

    // the first of two queued results never closes the run
    a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == 2'd2 |-> !slot0_reg.last_of_run)
        else $error("first of two results marked last");

    // an idle scanner holds no partial token
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ctc_pkg::MODE_IDLE |-> acc_reg == 32'd0 && cnt_reg == 8'd0)
        else $error("idle scanner holds token data");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 32'd0)
        else $error("line count reached zero");

    // a character that extends a token gives no result
    a_extend_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        push && continues |=> fill_reg == 2'd0 || (fill_reg == $past(fill_reg) - 2'd1))
        else $error("result produced while a token was extended");

endmodule

// ===== dv/ctc_token_checker.sv =====
module ctc_token_checker (
    input  logic clk,
    input  logic rst_n,
    ctc_char_if  chars,
    ctc_token_if tokens,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    ctc_pkg::mode_t   mode;
    logic [31:0]      num_acc;
    logic [63:0]      word_buf;
    logic [7:0]       word_len;
    logic [31:0]      lines;
    ctc_pkg::result_t expected_tokens[$];
    ctc_pkg::result_t staged[2];
    int               n_staged;
    int               errors;
    ctc_pkg::result_t got;
    ctc_pkg::result_t want;

    function automatic logic is_digit(logic [7:0] c);
        return c >= ctc_pkg::CH_ZERO && c <= ctc_pkg::CH_ZERO + 8'd9;
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == ctc_pkg::CH_UNDERSCORE
               || c == ctc_pkg::CH_DOLLAR;
    endfunction

    task automatic stage(ctc_pkg::kind_t kind, logic [31:0] num, logic [3:0] kw,
                         logic [63:0] text, logic [7:0] len, logic [7:0] sym);
        ctc_pkg::result_t r;
        r.token_kind     = kind;
        r.number_value   = num;
        r.keyword_number = kw;
        r.word_text      = text;
        r.word_length    = len;
        r.symbol_code    = sym;
        r.line_total     = lines;
        r.last_of_run    = 1'b0;
        staged[n_staged] = r;
        n_staged++;
    endtask

    task automatic add_word_char(logic [7:0] c);
        if (word_len < ctc_pkg::WORD_CHARS_KEPT)
        begin
            word_buf[8 * int'(word_len) +: 8] = c;
        end
        if (word_len != 8'hff)
        begin
            word_len++;
        end
    endtask

    // emit whatever token is pending and go back to idle
    task automatic close_token();
        int kw;
        kw = -1;
        if (mode == ctc_pkg::MODE_NUM)
        begin
            stage(ctc_pkg::KIND_NUMBER, num_acc, 4'd0, 64'd0, 8'd0, 8'd0);
        end
        else if (mode == ctc_pkg::MODE_WORD)
        begin
            for (int i = 0; i < ctc_pkg::NUM_KEYWORDS; i++)
            begin
                if (kw < 0 && word_len == ctc_pkg::KW_LEN[i]
                    && word_buf == ctc_pkg::KW_TEXT[i])
                begin
                    kw = i;
                end
            end
            if (kw >= 0)
            begin
                stage(ctc_pkg::KIND_KEYWORD, 32'd0, 4'(kw), word_buf, word_len, 8'd0);
            end
            else
            begin
                stage(ctc_pkg::KIND_IDENTIFIER, 32'd0, 4'd0, word_buf, word_len, 8'd0);
            end
        end
        mode     = ctc_pkg::MODE_IDLE;
        num_acc  = '0;
        word_buf = '0;
        word_len = '0;
    endtask

    task automatic scan_char(logic [7:0] c, logic eot);
        logic [35:0] grown;
        logic        absorbed;
        absorbed = 1'b0;
        n_staged = 0;
        if (eot)
        begin
            close_token();
            stage(ctc_pkg::KIND_LINES, 32'd0, 4'd0, 64'd0, 8'd0, 8'd0);
            lines = 32'd1;
        end
        else
        begin
            if (mode == ctc_pkg::MODE_NUM && is_digit(c))
            begin
                grown    = {4'd0, num_acc} * 36'd10 + 36'(c - ctc_pkg::CH_ZERO);
                num_acc  = grown > 36'hffff_ffff ? 32'hffff_ffff : grown[31:0];
                absorbed = 1'b1;
            end
            else if (mode == ctc_pkg::MODE_WORD && is_word_char(c))
            begin
                add_word_char(c);
                absorbed = 1'b1;
            end
            else
            begin
                close_token();
            end

            if (!absorbed)
            begin
                if (is_digit(c))
                begin
                    mode    = ctc_pkg::MODE_NUM;
                    num_acc = 32'(c - ctc_pkg::CH_ZERO);
                end
                else if (is_letter(c))
                begin
                    mode     = ctc_pkg::MODE_WORD;
                    word_buf = '0;
                    word_len = '0;
                    add_word_char(c);
                end
                else if (c == ctc_pkg::CH_NEWLINE)
                begin
                    if (lines != 32'hffff_ffff)
                    begin
                        lines++;
                    end
                end
                else if (c != ctc_pkg::CH_SPACE && c != ctc_pkg::CH_TAB)
                begin
                    stage(ctc_pkg::KIND_SYMBOL, 32'd0, 4'd0, 64'd0, 8'd0, c);
                end
            end
        end

        if (n_staged > 0)
        begin
            staged[n_staged - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n_staged; i++)
        begin
            expected_tokens.push_back(staged[i]);
        end
    endtask

    task automatic report(string what, ctc_pkg::result_t exp_r, ctc_pkg::result_t act_r);
        errors++;
        if (errors <= REPORT_MAX)
        begin
            $display("token check failed (%s), expected/actual: kind %0d/%0d",
                     what, exp_r.token_kind, act_r.token_kind);
            $display("    value %0d/%0d kw %0d/%0d",
                     exp_r.number_value, act_r.number_value,
                     exp_r.keyword_number, act_r.keyword_number);
            $display("    text %h/%h len %0d/%0d sym %h/%h lines %0d/%0d last %b/%b",
                     exp_r.word_text, act_r.word_text, exp_r.word_length, act_r.word_length,
                     exp_r.symbol_code, act_r.symbol_code, exp_r.line_total, act_r.line_total,
                     exp_r.last_of_run, act_r.last_of_run);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode     = ctc_pkg::MODE_IDLE;
            num_acc  = '0;
            word_buf = '0;
            word_len = '0;
            lines    = 32'd1;
            errors   = 0;
            expected_tokens.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (tokens.valid && tokens.ready)
            begin
                got = {tokens.token_kind, tokens.number_value, tokens.keyword_number,
                       tokens.word_text, tokens.word_length, tokens.symbol_code,
                       tokens.line_total, tokens.last_of_run};
                if (expected_tokens.size() == 0)
                begin
                    report("unexpected token", '0, got);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        report("field differs", want, got);
                    end
                end
            end
            // results of this request cannot appear before the next edge
            if (chars.valid && chars.ready)
            begin
                scan_char(chars.char_code, chars.end_of_text);
            end
            mismatches  <= errors;
            outstanding <= expected_tokens.size();
        end
    end

endmodule

// ===== dv/tb_c_token_classifier_unit.sv =====
module tb_c_token_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT     = 17;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          RANDOM_CHARS = 1100;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [7:0]  CH_RETURN    = 8'h0d;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   sent;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles;

    ctc_char_if  chars ();
    ctc_token_if tokens ();

    c_token_classifier_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens)
    );

    ctc_token_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .tokens      (tokens),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        tokens.ready <= steady || $urandom_range(99) >= IDLE_PCT;
    end

    // ends the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (chars.valid && chars.ready) || (tokens.valid && tokens.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("c_token_classifier_unit: mismatch");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send(logic [7:0] c, logic eot);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            chars.valid <= 1'b0;
            @(negedge clk);
        end
        chars.valid       <= 1'b1;
        chars.char_code   <= c;
        chars.end_of_text <= eot;
        @(posedge clk);
        while (!chars.ready)
        begin
            @(posedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? "A" : "a";
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] any_digit();
        return ctc_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] any_word_char();
        case ($urandom_range(3))
            0: return any_digit();
            1: return $urandom_range(1) ? ctc_pkg::CH_UNDERSCORE : ctc_pkg::CH_DOLLAR;
            default: return any_letter();
        endcase
    endfunction

    task automatic send_random_token();
        int         pick;
        int         len;
        int         k;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            // mostly short numbers, a few long enough to saturate
            len = $urandom_range(9) == 0 ? $urandom_range(14, 10) : $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
            begin
                send(any_digit(), 1'b0);
            end
        end
        else if (pick < 36)
        begin
            // keywords, with near misses: extra char, missing char, capital
            k   = $urandom_range(ctc_pkg::NUM_KEYWORDS - 1);
            len = int'(ctc_pkg::KW_LEN[k]);
            case ($urandom_range(7))
                0: len = len - 1;
                default: ;
            endcase
            for (int j = 0; j < len; j++)
            begin
                c = ctc_pkg::KW_TEXT[k][8 * j +: 8];
                if (j == 0 && $urandom_range(7) == 0)
                begin
                    c = c - 8'h20;
                end
                send(c, 1'b0);
            end
            if ($urandom_range(7) == 0)
            begin
                send(any_word_char(), 1'b0);
            end
        end
        else if (pick < 56)
        begin
            len = $urandom_range(79) == 0 ? $urandom_range(270, 250) : $urandom_range(11);
            send(any_letter(), 1'b0);
            for (int i = 0; i < len; i++)
            begin
                send(any_word_char(), 1'b0);
            end
        end
        else if (pick < 72)
        begin
            send(8'($urandom_range(255)), 1'b0);
        end
        else if (pick < 93)
        begin
            case ($urandom_range(3))
                0: send(ctc_pkg::CH_SPACE, 1'b0);
                1: send(ctc_pkg::CH_TAB, 1'b0);
                2: send(ctc_pkg::CH_NEWLINE, 1'b0);
                default: send(CH_RETURN, 1'b0);
            endcase
        end
        else
        begin
            send(8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial
    begin
        int base_count;
        chars.valid       = 1'b0;
        chars.char_code   = '0;
        chars.end_of_text = 1'b0;
        rst_n             = 1'b0;
        steady            = 1'b0;
        sent              = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one past the largest number, closed by a symbol in the same request
        send_text("4294967296;");
        // ten times the value passes the top bit of a narrow product
        send_text("35000000000 ");
        send(8'h00, 1'b0);
        send(8'hff, 1'b0);
        send(CH_RETURN, 1'b0);
        send(ctc_pkg::CH_NEWLINE, 1'b0);
        send(ctc_pkg::CH_TAB, 1'b0);
        send_text("Zz_$9 ");
        // keyword flushed by end of text, character ignored
        send_text("do");
        send(8'hff, 1'b1);

        base_count = sent;
        while (sent - base_count < RANDOM_CHARS)
        begin
            steady = (sent - base_count >= 400) && (sent - base_count < 650);
            send_random_token();
        end
        steady = 1'b0;
        send(8'($urandom_range(255)), 1'b1);
        chars.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("c_token_classifier_unit: match");
        end
        else
        begin
            $display("c_token_classifier_unit: mismatch");
        end
        $finish;
    end

endmodule
